// ===== hdl/ckey_pkg.sv =====
// Shared types, key codes, command and status structures for the keystroke calculator.
`default_nettype none

package ckey_pkg;

  typedef logic [31:0] word_t;

  // Key characters
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_TIMES  = 8'h2A;
  localparam logic [7:0] CHAR_DIVIDE = 8'h2F;
  localparam logic [7:0] CHAR_SIGN   = 8'h53;
  localparam logic [7:0] CHAR_CLEAR  = 8'h43;
  localparam logic [7:0] CHAR_RECALL = 8'h52;
  localparam logic [7:0] CHAR_MPLUS  = 8'h50;
  localparam logic [7:0] CHAR_MMINUS = 8'h4D;
  localparam logic [7:0] CHAR_EQUAL  = 8'h3D;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_INVALID  = 2'd2;

  localparam word_t MIN_WORD = 32'h8000_0000;
  localparam word_t NEG_ONE  = 32'hFFFF_FFFF;

  // The iterative unit runs one step per cycle over all 32 bits.
  localparam int          IterW     = 5;
  localparam logic [IterW-1:0] ITER_LAST = 5'd31;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    KEY_DIGIT,
    KEY_OPER,
    KEY_SPACE,
    KEY_SIGN,
    KEY_EQUAL,
    KEY_CLEAR,
    KEY_RECALL,
    KEY_MEM,
    KEY_INVALID
  } key_class_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_APPLY,
    S_ITER,
    S_WRITE,
    S_POST,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic latch;
    logic decode;
    logic apply;
    logic iter_step;
    logic write;
    logic post;
    logic emit_load;
  } ckey_cmd_t;

  typedef struct packed {
    key_class_t key_class;
    logic       finished;
    logic       prev_op;
    logic       final_key;
    logic       apply_iter;
    logic       iter_last;
  } ckey_sts_t;

  function automatic key_class_t classify_key(input logic [7:0] k);
    key_class_t c;
    c = KEY_INVALID;
    if (k >= CHAR_ZERO && k <= CHAR_NINE) c = KEY_DIGIT;
    else if (k == CHAR_PLUS || k == CHAR_MINUS || k == CHAR_TIMES || k == CHAR_DIVIDE)
      c = KEY_OPER;
    else if (k == CHAR_SPACE) c = KEY_SPACE;
    else if (k == CHAR_SIGN) c = KEY_SIGN;
    else if (k == CHAR_EQUAL) c = KEY_EQUAL;
    else if (k == CHAR_CLEAR) c = KEY_CLEAR;
    else if (k == CHAR_RECALL) c = KEY_RECALL;
    else if (k == CHAR_MPLUS || k == CHAR_MMINUS) c = KEY_MEM;
    return c;
  endfunction

  function automatic op_t key_to_op(input logic [7:0] k);
    op_t o;
    case (k)
      CHAR_PLUS:  o = OP_ADD;
      CHAR_MINUS: o = OP_SUB;
      CHAR_TIMES: o = OP_MUL;
      default:    o = OP_DIV;
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ckey_datapath.sv =====
// Datapath: calculator registers, term arithmetic, iterative multiply/divide unit, result register.
`default_nettype none

module ckey_datapath
  import ckey_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [7:0]   key_char,
  input  wire logic         start_flag,
  input  wire logic         final_flag,
  input  wire ckey_cmd_t    cmd,
  output ckey_sts_t         sts,
  output logic signed [31:0] result_value,
  output logic [1:0]        result_status
);

  logic [7:0] key_q;
  logic       final_q;

  word_t accumulator;
  word_t entry_value;
  word_t memory_value;
  op_t   pending_op;
  logic  negate_term;
  logic  after_op;
  logic  skip_sign;
  logic  overflow_seen;
  logic  finished;

  // Iterative unit
  word_t            u_m;
  logic [32:0]      u_hi;
  word_t            u_lo;
  logic [IterW-1:0] u_cnt;
  logic             u_neg;
  logic             u_div;

  key_class_t  key_class;
  logic [35:0] ent_ext;
  logic [35:0] ent_x10;
  logic        x10_ovf;
  word_t       digit_sum;
  logic        digit_ovf;
  word_t       term;
  logic        term_ovf;
  word_t       add_r;
  word_t       sub_r;
  logic        add_ovf;
  logic        sub_ovf;
  logic        div_bad;
  word_t       mag_acc;
  word_t       mag_term;
  logic [32:0] mul_sum;
  logic [32:0] div_sh;
  logic [33:0] div_diff;
  word_t       mul_res;
  logic        mul_ovf;
  word_t       div_res;
  word_t       mem_add;
  word_t       mem_sub;
  logic        mem_add_ovf;
  logic        mem_sub_ovf;

  always_comb begin
    key_class = classify_key(key_q);

    // entry * 10 as (entry << 3) + (entry << 1), then plus the digit
    ent_ext   = {{4{entry_value[31]}}, entry_value};
    ent_x10   = (ent_ext << 3) + (ent_ext << 1);
    x10_ovf   = !((&ent_x10[35:31]) || !(|ent_x10[35:31]));
    digit_sum = ent_x10[31:0] + {28'd0, key_q[3:0]};
    digit_ovf = !ent_x10[31] && digit_sum[31];

    // Negating the most negative value leaves it unchanged and flags overflow.
    term     = negate_term ? (32'd0 - entry_value) : entry_value;
    term_ovf = negate_term && (entry_value == MIN_WORD);

    add_r   = accumulator + term;
    sub_r   = accumulator - term;
    add_ovf = ((accumulator ^ add_r) & (term ^ add_r)) >> 31 != 32'd0;
    sub_ovf = ((accumulator ^ term) & (accumulator ^ sub_r)) >> 31 != 32'd0;
    div_bad = (term == 32'd0) || (accumulator == MIN_WORD && term == NEG_ONE);

    mag_acc  = accumulator[31] ? (32'd0 - accumulator) : accumulator;
    mag_term = term[31] ? (32'd0 - term) : term;

    mul_sum  = {1'b0, u_hi[31:0]} + (u_lo[0] ? {1'b0, u_m} : 33'd0);
    div_sh   = {u_hi[31:0], u_lo[31]};
    div_diff = {1'b0, div_sh} - {2'b00, u_m};

    mul_res = u_neg ? (32'd0 - u_lo) : u_lo;
    mul_ovf = u_neg ? ((|u_hi[31:0]) || (u_lo[31] && (|u_lo[30:0])))
                    : ((|u_hi[31:0]) || u_lo[31]);
    div_res = u_neg ? (32'd0 - u_lo) : u_lo;

    mem_add     = memory_value + accumulator;
    mem_sub     = memory_value - accumulator;
    mem_add_ovf = ((memory_value ^ mem_add) & (accumulator ^ mem_add)) >> 31 != 32'd0;
    mem_sub_ovf = ((memory_value ^ accumulator) & (memory_value ^ mem_sub)) >> 31 != 32'd0;
  end

  assign sts.key_class  = key_class;
  assign sts.finished   = finished;
  assign sts.prev_op    = after_op;
  assign sts.final_key  = final_q;
  assign sts.apply_iter = (pending_op == OP_MUL) || (pending_op == OP_DIV && !div_bad);
  assign sts.iter_last  = (u_cnt == ITER_LAST);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      key_q   <= key_char;
      final_q <= final_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= '0;
      entry_value   <= '0;
      memory_value  <= '0;
      pending_op    <= OP_ADD;
      negate_term   <= 1'b0;
      after_op      <= 1'b0;
      skip_sign     <= 1'b0;
      overflow_seen <= 1'b0;
      finished      <= 1'b0;
    end else begin
      if (cmd.latch && start_flag) begin
        accumulator   <= '0;
        entry_value   <= '0;
        memory_value  <= '0;
        pending_op    <= OP_ADD;
        negate_term   <= 1'b0;
        after_op      <= 1'b0;
        skip_sign     <= 1'b0;
        overflow_seen <= 1'b0;
        finished      <= 1'b0;
      end

      if (cmd.decode && !finished) begin
        after_op  <= 1'b0;
        skip_sign <= 1'b0;
        if (final_q) finished <= 1'b1;
        case (key_class)
          KEY_DIGIT: begin
            entry_value <= digit_sum;
            if (x10_ovf || digit_ovf) overflow_seen <= 1'b1;
          end
          KEY_OPER: begin
            after_op  <= 1'b1;
            skip_sign <= 1'b1;
            if (after_op) pending_op <= key_to_op(key_q);
          end
          KEY_SIGN: begin
            if (skip_sign) skip_sign <= 1'b1;
            else negate_term <= !negate_term;
          end
          KEY_CLEAR: begin
            accumulator  <= '0;
            memory_value <= '0;
            entry_value  <= '0;
            negate_term  <= 1'b0;
            pending_op   <= OP_ADD;
          end
          KEY_RECALL: begin
            accumulator <= memory_value;
            if (!final_q) begin
              entry_value <= '0;
              negate_term <= 1'b0;
              pending_op  <= OP_ADD;
            end
          end
          KEY_EQUAL, KEY_INVALID: begin
            finished <= 1'b1;
          end
          default: begin
          end
        endcase
      end

      if (cmd.apply) begin
        if (term_ovf) overflow_seen <= 1'b1;
        case (pending_op)
          OP_ADD: begin
            accumulator <= add_r;
            if (add_ovf) overflow_seen <= 1'b1;
          end
          OP_SUB: begin
            accumulator <= sub_r;
            if (sub_ovf) overflow_seen <= 1'b1;
          end
          OP_DIV: begin
            if (div_bad) overflow_seen <= 1'b1;
          end
          default: begin
          end
        endcase
      end

      if (cmd.write) begin
        if (u_div) begin
          accumulator <= div_res;
        end else begin
          accumulator <= mul_res;
          if (mul_ovf) overflow_seen <= 1'b1;
        end
      end

      if (cmd.post) begin
        case (key_class)
          KEY_OPER: begin
            entry_value <= '0;
            negate_term <= 1'b0;
            pending_op  <= key_to_op(key_q);
          end
          KEY_MEM: begin
            if (key_q == CHAR_MPLUS) begin
              memory_value <= mem_add;
              if (mem_add_ovf) overflow_seen <= 1'b1;
            end else begin
              memory_value <= mem_sub;
              if (mem_sub_ovf) overflow_seen <= 1'b1;
            end
            accumulator <= '0;
            entry_value <= '0;
            negate_term <= 1'b0;
            pending_op  <= OP_ADD;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Shift-add multiply on magnitudes, low bit first; restoring divide, high bit first.
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      u_cnt <= '0;
      u_div <= (pending_op == OP_DIV);
      u_neg <= accumulator[31] ^ term[31];
      u_hi  <= '0;
      u_m   <= (pending_op == OP_DIV) ? mag_term : mag_acc;
      u_lo  <= (pending_op == OP_DIV) ? mag_acc : mag_term;
    end else if (cmd.iter_step) begin
      u_cnt <= u_cnt + 1'b1;
      if (u_div) begin
        if (!div_diff[33]) begin
          u_hi <= div_diff[32:0];
          u_lo <= {u_lo[30:0], 1'b1};
        end else begin
          u_hi <= div_sh;
          u_lo <= {u_lo[30:0], 1'b0};
        end
      end else begin
        u_hi <= {1'b0, mul_sum[32:1]};
        u_lo <= {mul_sum[0], u_lo[31:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      if (key_class == KEY_INVALID) begin
        result_value  <= '0;
        result_status <= STATUS_INVALID;
      end else if (overflow_seen) begin
        result_value  <= '0;
        result_status <= STATUS_OVERFLOW;
      end else begin
        result_value  <= accumulator;
        result_status <= STATUS_OK;
      end
    end
  end

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    $fell(overflow_seen) |-> $past(rst) || $past(cmd.latch && start_flag))
    else $error("overflow flag cleared without a start request");

  a_finished_sticky: assert property (@(posedge clk) disable iff (rst)
    $fell(finished) |-> $past(rst) || $past(cmd.latch && start_flag))
    else $error("finished flag cleared without a start request");

  a_memory_writers: assert property (@(posedge clk) disable iff (rst)
    !$stable(memory_value) |-> $past(rst) || $past(cmd.latch && start_flag)
      || $past(cmd.decode && key_class == KEY_CLEAR)
      || $past(cmd.post && key_class == KEY_MEM))
    else $error("memory changed outside clear, start or memory keys");

endmodule

`default_nettype wire

// ===== hdl/ckey_ctrl.sv =====
// Controller state machine sequencing decode, term application, iteration and emission.
`default_nettype none

module ckey_ctrl
  import ckey_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire ckey_sts_t sts,
  output ckey_cmd_t      cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = S_IDLE;
        if (!sts.finished) begin
          case (sts.key_class)
            KEY_OPER:    state_next = sts.prev_op ? S_IDLE : S_APPLY;
            KEY_EQUAL:   state_next = S_APPLY;
            KEY_MEM:     state_next = S_APPLY;
            KEY_RECALL:  state_next = sts.final_key ? S_EMIT : S_IDLE;
            KEY_INVALID: state_next = S_EMIT;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_APPLY: state_next = sts.apply_iter ? S_ITER : S_POST;
      S_ITER:  state_next = sts.iter_last ? S_WRITE : S_ITER;
      S_WRITE: state_next = S_POST;
      S_POST:  state_next = (sts.key_class == KEY_EQUAL) ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_DECODE: cmd.decode    = 1'b1;
      S_APPLY:  cmd.apply     = 1'b1;
      S_ITER:   cmd.iter_step = 1'b1;
      S_WRITE:  cmd.write     = 1'b1;
      S_POST:   cmd.post      = 1'b1;
      S_EMIT:   cmd.emit_load = out_free;
      default: begin
      end
    endcase
    out_valid_next = cmd.emit_load ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_DECODE)
    else $error("accepted request not decoded");

  a_iter_full_length: assert property (@(posedge clk) disable iff (rst)
    state == S_ITER && !sts.iter_last |=> state == S_ITER)
    else $error("iterative unit left before its last step");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EMIT)
    else $error("result raised outside the emit state");

endmodule

`default_nettype wire

// ===== hdl/calculator_keystroke_engine_top.sv =====
// Top level of the keystroke calculator: controller and datapath joined by command and status.
// A digit, space, sign, clear or recall key is latched in the idle state and decoded; an operator
//   not following an operator, '=', 'P' or 'M' also passes the apply and post states, and a pending
//   multiply or valid divide runs the 32-step shift-add / restoring unit in between. A result adds the
//   emit state. Throughput: one request at a time; the output register lets the next request in
//   while a result waits to be taken. Reset (rst, synchronous) clears all calculator state.
`default_nettype none

module calculator_keystroke_engine_top
  import ckey_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   key_char,
  input  wire logic         start_flag,
  input  wire logic         final_flag,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic signed [31:0] result_value,
  output logic [1:0]        result_status
);

  // The controller only sequences; every calculator register lives in the datapath.
  ckey_cmd_t cmd;
  ckey_sts_t sts;

  // The controller owns the handshakes. A request is latched in the idle state, then decoded;
  // keys that apply a term go through the apply state and, for multiply or divide, through
  // the iteration and write states before the post step clears the term or updates the memory.
  ckey_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the accumulator, entry, memory, flags, the shared iterative
  // multiply/divide unit and the result register that drives the output payload.
  ckey_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .key_char      (key_char),
    .start_flag    (start_flag),
    .final_flag    (final_flag),
    .cmd           (cmd),
    .sts           (sts),
    .result_value  (result_value),
    .result_status (result_status)
  );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the keystroke calculator: randomised key requests against a predictor.
`default_nettype none

module tb;
  import ckey_pkg::*;

  // A cycle count with nothing accepted while work is outstanding; far beyond the slowest
  // legitimate stretch (longest sender gap, a multiply or divide, longest stall).
  localparam int QuietLimit  = 3000;
  // Cycles allowed after the last expected result before the verdict is drawn.
  localparam int DrainCycles = 80;
  // Rough number of key requests that the random part aims for.
  localparam int KeyTarget   = 1125;

  typedef struct {
    logic [7:0] key;
    logic       first;
    logic       last;
  } keypress_t;

  typedef struct packed {
    word_t      value;
    logic [1:0] status;
  } calc_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         key_char = 8'h00;
  logic               start_flag = 1'b0;
  logic               final_flag = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] result_value;
  logic [1:0]         result_status;

  calculator_keystroke_engine_top uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .key_char     (key_char),
    .start_flag   (start_flag),
    .final_flag   (final_flag),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .result_status(result_status)
  );

  // Period of 12 time units.
  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // ---------------------------------------------------------------------------------------------
  // Predictor state: a private copy of everything the calculator keeps between key requests.
  // ---------------------------------------------------------------------------------------------
  word_t calc_acc;
  word_t calc_entry;
  word_t calc_mem;
  op_t   calc_op;
  logic  calc_neg;
  logic  calc_after_op;
  logic  calc_skip_sign;
  logic  calc_ovf;
  logic  calc_done;

  calc_result_t expected_results[$];
  keypress_t    key_requests[$];
  logic [7:0]   expr_keys[$];

  int mismatches    = 0;
  int results_seen  = 0;
  int keys_taken    = 0;
  int expressions   = 0;
  int planned_keys  = 0;
  int ok_seen       = 0;
  int overflow_seen = 0;
  int invalid_seen  = 0;

  // Handshake bookkeeping for the driver, the receiver and the monitor.
  int taken_count  = 0;
  int issued_count = 0;
  int burst_left   = 1;
  int gap_left     = 0;
  int stall_mode   = 0;
  int stall_span   = 0;
  int stall_phase  = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  keypress_t    next_req;
  calc_result_t want;

  task automatic calc_reset();
    calc_acc       = '0;
    calc_entry     = '0;
    calc_mem       = '0;
    calc_op        = OP_ADD;
    calc_neg       = 1'b0;
    calc_after_op  = 1'b0;
    calc_skip_sign = 1'b0;
    calc_ovf       = 1'b0;
    calc_done      = 1'b0;
  endtask

  // Signed 32-bit arithmetic; each helper latches the overflow flag as a side effect.
  function automatic word_t add_chk(word_t a, word_t b);
    word_t r;
    r = a + b;
    if (((a ^ r) & (b ^ r)) & MIN_WORD) calc_ovf = 1'b1;
    return r;
  endfunction

  function automatic word_t sub_chk(word_t a, word_t b);
    word_t r;
    r = a - b;
    if (((a ^ b) & (a ^ r)) & MIN_WORD) calc_ovf = 1'b1;
    return r;
  endfunction

  function automatic word_t mul_chk(word_t a, word_t b);
    longint p;
    p = longint'($signed(a)) * longint'($signed(b));
    if (p > 64'sd2147483647 || p < -64'sd2147483648) calc_ovf = 1'b1;
    return p[31:0];
  endfunction

  function automatic word_t div_chk(word_t a, word_t b);
    longint q;
    // Division by zero and MIN / -1 both leave the accumulator as it was.
    if (b == '0 || (a == MIN_WORD && b == NEG_ONE)) begin
      calc_ovf = 1'b1;
      return a;
    end
    q = longint'($signed(a)) / longint'($signed(b));
    return q[31:0];
  endfunction

  // Folds the signed entry into the accumulator under the pending operator.
  task automatic apply_term();
    word_t t;
    t = calc_entry;
    if (calc_neg) begin
      // Negating MIN cannot be represented: the term keeps MIN and overflow is latched.
      if (t == MIN_WORD) calc_ovf = 1'b1;
      else t = -t;
    end
    case (calc_op)
      OP_ADD:  calc_acc = add_chk(calc_acc, t);
      OP_SUB:  calc_acc = sub_chk(calc_acc, t);
      OP_MUL:  calc_acc = mul_chk(calc_acc, t);
      default: calc_acc = div_chk(calc_acc, t);
    endcase
  endtask

  task automatic clear_term();
    calc_entry = '0;
    calc_neg   = 1'b0;
    calc_op    = OP_ADD;
  endtask

  task automatic emit_result(logic [1:0] status);
    calc_result_t r;
    if (status == STATUS_OK && calc_ovf) status = STATUS_OVERFLOW;
    r.status = status;
    r.value  = (status == STATUS_OK) ? calc_acc : '0;
    expected_results.push_back(r);
    calc_done = 1'b1;
  endtask

  // Advances the predictor by one accepted key request.
  task automatic press_key(logic [7:0] k, logic first, logic last);
    logic   was_op;
    logic   was_skip;
    longint p;
    if (first) calc_reset();
    if (!calc_done) begin
      was_op         = calc_after_op;
      was_skip       = calc_skip_sign;
      calc_after_op  = 1'b0;
      calc_skip_sign = 1'b0;
      if (k >= CHAR_ZERO && k <= CHAR_NINE) begin
        p = longint'($signed(calc_entry)) * 10;
        if (p > 64'sd2147483647 || p < -64'sd2147483648) calc_ovf = 1'b1;
        calc_entry = add_chk(p[31:0], {24'd0, k - CHAR_ZERO});
      end else if (k == CHAR_PLUS || k == CHAR_MINUS || k == CHAR_TIMES || k == CHAR_DIVIDE)
      begin
        // Within a run of adjacent operators only the last one takes effect.
        if (!was_op) begin
          apply_term();
          clear_term();
        end
        case (k)
          CHAR_PLUS:  calc_op = OP_ADD;
          CHAR_MINUS: calc_op = OP_SUB;
          CHAR_TIMES: calc_op = OP_MUL;
          default:    calc_op = OP_DIV;
        endcase
        calc_after_op  = 1'b1;
        calc_skip_sign = 1'b1;
      end else if (k == CHAR_SPACE) begin
        // A space only breaks an operator run and the skipping of sign keys.
      end else if (k == CHAR_SIGN) begin
        if (was_skip) calc_skip_sign = 1'b1;
        else calc_neg = !calc_neg;
      end else if (k == CHAR_EQUAL) begin
        apply_term();
        emit_result(STATUS_OK);
      end else if (k == CHAR_CLEAR) begin
        calc_acc = '0;
        calc_mem = '0;
        clear_term();
      end else if (k == CHAR_RECALL) begin
        calc_acc = calc_mem;
        if (last) emit_result(STATUS_OK);
        else clear_term();
      end else if (k == CHAR_MPLUS || k == CHAR_MMINUS) begin
        apply_term();
        if (k == CHAR_MPLUS) calc_mem = add_chk(calc_mem, calc_acc);
        else calc_mem = sub_chk(calc_mem, calc_acc);
        calc_acc = '0;
        clear_term();
      end else begin
        emit_result(STATUS_INVALID);
      end
      if (last) calc_done = 1'b1;
    end
  endtask

  task automatic report_mismatch(string what, word_t got, word_t exp_val);
    $display("%0t: result %0d %s: got %h, expected %h", $realtime, results_seen, what, got,
             exp_val);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------------------------
  // Stimulus building: keys are gathered into one expression, then flagged and queued.
  // ---------------------------------------------------------------------------------------------
  task automatic push_request(logic [7:0] k, logic first, logic last);
    keypress_t r;
    r.key   = k;
    r.first = first;
    r.last  = last;
    key_requests.push_back(r);
    planned_keys++;
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) expr_keys.push_back(s[i]);
  endtask

  // Queues the gathered expression; start marks the first key, final the last one.
  task automatic flush_expr(logic with_start, logic with_final);
    int n;
    n = expr_keys.size();
    for (int i = 0; i < n; i++)
      push_request(expr_keys[i], with_start && i == 0, with_final && i == n - 1);
    expr_keys.delete();
    expressions++;
  endtask

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 3))
      0:       return CHAR_PLUS;
      1:       return CHAR_MINUS;
      2:       return CHAR_TIMES;
      default: return CHAR_DIVIDE;
    endcase
  endfunction

  // Mostly small numbers, with a share of long and boundary values that can force overflow.
  task automatic add_number();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) add_text($sformatf("%0d", $urandom_range(0, 99)));
    else if (pick < 65) add_text($sformatf("%0d", $urandom_range(0, 99999)));
    else if (pick < 80) add_text($sformatf("%0d", $urandom));
    else begin
      case ($urandom_range(0, 5))
        0:       add_text("2147483647");
        1:       add_text("2147483648");
        2:       add_text("0");
        3:       add_text("1");
        4:       add_text("007");
        default: add_text("99999999999");
      endcase
    end
  endtask

  task automatic queue_random_expr();
    int   terms;
    int   ending;
    logic with_start;
    terms      = $urandom_range(1, 6);
    with_start = ($urandom_range(0, 19) != 0);
    for (int t = 0; t < terms; t++) begin
      if (t > 0) begin
        expr_keys.push_back(random_operator());
        // Operator runs, sign keys right after an operator, and a space that ends skipping.
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 2)) expr_keys.push_back(random_operator());
        if ($urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 2) == 0) expr_keys.push_back(CHAR_SPACE);
          expr_keys.push_back(CHAR_SIGN);
        end
      end
      if ($urandom_range(0, 6) == 0) expr_keys.push_back(CHAR_SIGN);
      add_number();
      if ($urandom_range(0, 6) == 0) expr_keys.push_back(CHAR_SIGN);
      if ($urandom_range(0, 9) == 0) expr_keys.push_back(CHAR_SPACE);
      case ($urandom_range(0, 49))
        0, 1, 2: expr_keys.push_back(CHAR_MPLUS);
        3, 4:    expr_keys.push_back(CHAR_MMINUS);
        5, 6:    expr_keys.push_back(CHAR_CLEAR);
        7, 8:    expr_keys.push_back(CHAR_RECALL);
        9:       expr_keys.push_back(8'($urandom_range(0, 255)));
        default: ;
      endcase
    end
    ending = $urandom_range(0, 99);
    if (ending < 70) begin
      expr_keys.push_back(CHAR_EQUAL);
      flush_expr(with_start, 1'b1);
    end else if (ending < 82) begin
      expr_keys.push_back(CHAR_RECALL);
      flush_expr(with_start, 1'b1);
    end else if (ending < 90) begin
      // The final key is a digit, so nothing is emitted.
      add_text($sformatf("%0d", $urandom_range(0, 9)));
      flush_expr(with_start, 1'b1);
    end else if (ending < 95) begin
      flush_expr(with_start, 1'b0);
    end else begin
      // An emission without the final flag; the trailing keys must be ignored.
      expr_keys.push_back(CHAR_EQUAL);
      add_number();
      expr_keys.push_back(CHAR_EQUAL);
      flush_expr(with_start, 1'b0);
    end
  endtask

  // Fixed expressions that reach the arithmetic corners.
  task automatic queue_corner_expr();
    case ($urandom_range(0, 7))
      0:       add_text("2147483647S-1/1S=");
      1:       add_text("2147483647S-1*1S=");
      2:       add_text("2147483647+1=");
      3:       add_text("65536*65536=");
      4:       add_text("7S/2=");
      5:       add_text("46341*46341=");
      6:       add_text("2147483647P1PR");
      default: add_text("1S-2147483647=");
    endcase
    flush_expr(1'b1, 1'b1);
  endtask

  // ---------------------------------------------------------------------------------------------
  // Driver: presents key requests at the falling edge, in bursts with random gaps.
  // A request is only replaced once the monitor has counted it as accepted.
  // ---------------------------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst && (!in_valid || taken_count == issued_count)) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (key_requests.size() > 0) begin
        next_req = key_requests.pop_front();
        key_char   <= next_req.key;
        start_flag <= next_req.first;
        final_flag <= next_req.last;
        in_valid   <= 1'b1;
        issued_count = issued_count + 1;
        if (burst_left > 1) begin
          burst_left = burst_left - 1;
        end else begin
          // Mostly short bursts and gaps, now and then a long back-to-back stretch.
          case ($urandom_range(0, 19))
            0, 1, 2: begin
              burst_left = $urandom_range(50, 150);
              gap_left   = 0;
            end
            3, 4: begin
              burst_left = $urandom_range(1, 16);
              gap_left   = $urandom_range(20, 60);
            end
            5, 6, 7, 8, 9, 10: begin
              burst_left = $urandom_range(1, 16);
              gap_left   = $urandom_range(3, 12);
            end
            default: begin
              burst_left = $urandom_range(1, 16);
              gap_left   = $urandom_range(0, 2);
            end
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: its own stall pattern, switching mode after a randomly drawn span.
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 200);
    end
    stall_span  = stall_span - 1;
    stall_phase = stall_phase + 1;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) < 7);
      2: out_ready <= (stall_phase % 4 == 0);
      default: begin
        if (hold_left > 0) begin
          hold_left = hold_left - 1;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 9) == 0) hold_left = $urandom_range(5, 30);
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------------------------
  // Monitor: samples both handshakes at the rising edge. Results are checked before the newly
  // accepted request is predicted, so a result can never be matched against its own request.
  // ---------------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("arrived with nothing expected", result_value, '0);
        end else begin
          want = expected_results.pop_front();
          if (result_status !== want.status)
            report_mismatch("status", word_t'(result_status), word_t'(want.status));
          if (result_value !== want.value)
            report_mismatch("value", result_value, want.value);
          case (want.status)
            STATUS_OK:       ok_seen++;
            STATUS_OVERFLOW: overflow_seen++;
            default:         invalid_seen++;
          endcase
        end
      end
      if (in_valid && in_ready) begin
        press_key(key_char, start_flag, final_flag);
        keys_taken++;
        taken_count <= taken_count + 1;
      end
      // Watchdog: only cycles with work outstanding and no handshake at all count.
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else if (in_valid || expected_results.size() > 0) quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no request accepted for %0d cycles", $realtime, QuietLimit);
        $display("[calculator_keystroke_engine_top] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Sequence: reset, fill the request queue, wait for everything to drain, then the verdict.
  // ---------------------------------------------------------------------------------------------
  initial begin
    calc_reset();

    // Directed part. An invalid NUL, a key ignored once finished, then an invalid top code.
    push_request(8'h00, 1'b1, 1'b0);
    push_request(CHAR_PLUS, 1'b0, 1'b0);
    push_request(8'hFF, 1'b1, 1'b1);
    // Division by zero.
    add_text("9/0=");
    flush_expr(1'b1, 1'b1);
    // An operator run where only the last counts, with the sign key after it skipped.
    add_text("5+*-S2=");
    flush_expr(1'b1, 1'b1);
    // Memory add and subtract, then recall as the final key.
    add_text("4P1MR");
    flush_expr(1'b1, 1'b1);
    // A clear, a space and a sign toggle as the final key: nothing is emitted.
    add_text("C7 S");
    flush_expr(1'b1, 1'b1);
    // Ignored while finished: no start flag.
    push_request(CHAR_EQUAL, 1'b0, 1'b0);
    // An overflowed entry that wraps to MIN, negated, then MIN divided by minus one.
    add_text("2147483648S/1S=");
    flush_expr(1'b1, 1'b1);

    // Random part: mostly well-formed expressions, some corner templates and some noise.
    while (planned_keys < KeyTarget) begin
      case ($urandom_range(0, 99)) inside
        [0:9]: begin
          repeat ($urandom_range(1, 5))
            push_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
        end
        [10:16]: queue_corner_expr();
        default: queue_random_expr();
      endcase
    end

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (key_requests.size() > 0 || taken_count != issued_count ||
           expected_results.size() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Covered %0d key requests in %0d expressions, %0d results checked.", keys_taken,
             expressions, results_seen);
    $display("Results by status: %0d ok, %0d overflow, %0d invalid; %0d mismatches.", ok_seen,
             overflow_seen, invalid_seen, mismatches);
    if (mismatches == 0) begin
      $display("[calculator_keystroke_engine_top] OK");
    end else begin
      $display("[calculator_keystroke_engine_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/ckey_pkg.sv
hdl/ckey_datapath.sv
hdl/ckey_ctrl.sv
hdl/calculator_keystroke_engine_top.sv
dv/tb.sv
